// File: rtl/core/bsca_pkg.sv
// package: types, register indexes and constants of the barometric compensation core
`timescale 1ns / 1ps

package bsca_pkg;

    localparam int WINDOW_LEN_DEF = 5;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS          = 3'd0,
        REG_OFFSET        = 3'd1,
        REG_SENS_TEMP     = 3'd2,
        REG_OFFSET_TEMP   = 3'd3,
        REG_REF_TEMP      = 3'd4,
        REG_TEMP_SLOPE    = 3'd5
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_SENS        = 16'd41269;
    localparam logic [CFG_W-1:0] RST_OFFSET      = 16'd35794;
    localparam logic [CFG_W-1:0] RST_SENS_TEMP   = 16'd23974;
    localparam logic [CFG_W-1:0] RST_OFFSET_TEMP = 16'd21783;
    localparam logic [CFG_W-1:0] RST_REF_TEMP    = 16'd33699;
    localparam logic [CFG_W-1:0] RST_TEMP_SLOPE  = 16'd28430;

    localparam logic signed [21:0] TEMP_BASE = 22'sd2000;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } t_in_req;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic signed [PRES_W-1:0] pressure_avg;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_TEMP,
        S_MUL_OFF,
        S_MUL_SENS,
        S_SENS,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_PRES,
        S_SUM,
        S_HIST,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// File: rtl/core/bsca_div.sv
// signed divide by a constant through reciprocal multiplication, quotient truncated toward zero
`timescale 1ns / 1ps

module bsca_div
    import bsca_pkg::*;
#(
    parameter int DIVISOR = WINDOW_LEN_DEF,
    parameter int IN_W    = 35
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [IN_W-1:0] i_dividend,
    output logic                   o_done,
    output logic signed [IN_W-1:0] o_quotient
);

    localparam int DIG_W   = 16;
    localparam int MAG_W   = IN_W;
    localparam int SHIFT_K = MAG_W + $clog2(DIVISOR);
    localparam int RCP_W   = MAG_W + 1;
    localparam int NDIG    = (RCP_W + DIG_W - 1) / DIG_W;
    localparam int RCP_PW  = NDIG * DIG_W;
    localparam int PART_W  = MAG_W + DIG_W;
    localparam int ACC_W   = MAG_W + RCP_PW;
    localparam int CNT_W   = $clog2(NDIG + 1);
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SHIFT_K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RCP_PW-1:0] RCP = RCP_PW'(RCP_FULL);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_neg, n_neg;
    logic [MAG_W-1:0]       r_mag, n_mag;
    logic [RCP_PW-1:0]      r_rcp, n_rcp;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic signed [IN_W-1:0] r_quot, n_quot;
    logic [PART_W-1:0]      part;
    logic [MAG_W-1:0]       q_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_rcp  <= n_rcp;
        r_acc  <= n_acc;
        r_quot <= n_quot;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_rcp  = r_rcp;
        n_acc  = r_acc;
        n_quot = r_quot;
        part   = {{DIG_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, r_rcp[RCP_PW-1 -: DIG_W]};
        q_mag  = MAG_W'(r_acc >> SHIFT_K);
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NDIG);
            n_neg  = i_dividend[IN_W-1];
            n_mag  = i_dividend[IN_W-1] ? MAG_W'(-i_dividend) : MAG_W'(i_dividend);
            n_rcp  = RCP;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                // one reciprocal digit per cycle, most significant first
                n_acc = {r_acc[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}}
                        + {{(ACC_W-PART_W){1'b0}}, part};
                n_rcp = {r_rcp[RCP_PW-DIG_W-1:0], {DIG_W{1'b0}}};
                n_cnt = r_cnt - CNT_W'(1);
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_quot = r_neg ? -$signed(q_mag) : $signed(q_mag);
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// File: rtl/core/baro_sensor_compensation_average_core.sv
// top level: barometric first-order compensation with a moving pressure average
`timescale 1ns / 1ps

// One request of raw pressure and temperature readings gives one result: the
// compensated temperature in hundredths of a degree and the truncated mean of
// the last WINDOW_LEN pressures. The core takes one request at a time: the
// sequencer runs a request around one shared 26 x 18 signed multiplier, then
// divides by the window length, done as a multiplication by its reciprocal one
// 16-bit digit per cycle plus a closing step, and hands the result into the
// output register. A finished result waits in the output register while the next
// request is already taken, and a result that finds the output register still
// full holds the core until the receiver takes the old one. Coefficients are
// written through the plain write port; the user must write them only while the
// core is idle, and the core itself does not enforce this. The pressure window
// starts at zero.
module baro_sensor_compensation_average_core
    import bsca_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_req             o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SUM_W  = PRES_W + $clog2(WINDOW_LEN);
    localparam int HIST_D = (WINDOW_LEN > 1) ? WINDOW_LEN - 1 : 1;

    // coefficient registers
    logic [CFG_W-1:0] r_sens_c, r_off_c, r_sens_t_c, r_off_t_c, r_ref_t, r_slope_c;

    t_state r_state, n_state;

    logic [RAW_W-1:0]         r_d1;
    logic signed [25:0]       r_dt;
    logic signed [43:0]       r_prod;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [37:0]       r_off;
    logic signed [33:0]       r_sens;
    logic signed [59:0]       r_acc;
    logic signed [PRES_W-1:0] r_p;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  r_hsum;
    logic signed [PRES_W-1:0] r_hist [HIST_D];
    logic                     r_out_valid;
    t_out_req                 r_out;

    logic signed [25:0] mul_a;
    logic signed [17:0] mul_b;
    logic               mul_en;
    logic               div_start;
    logic               div_done;
    logic signed [SUM_W-1:0] div_quot;
    logic               out_load;
    logic               in_acc;

    logic signed [21:0] temp_w;
    logic signed [37:0] off_w;
    logic signed [35:0] sens_w;
    logic signed [39:0] pres_diff;
    logic signed [PRES_W-1:0] oldest;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    // coefficient write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens_c   <= RST_SENS;
            r_off_c    <= RST_OFFSET;
            r_sens_t_c <= RST_SENS_TEMP;
            r_off_t_c  <= RST_OFFSET_TEMP;
            r_ref_t    <= RST_REF_TEMP;
            r_slope_c  <= RST_TEMP_SLOPE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SENS:        r_sens_c   <= i_cfg_data;
                REG_OFFSET:      r_off_c    <= i_cfg_data;
                REG_SENS_TEMP:   r_sens_t_c <= i_cfg_data;
                REG_OFFSET_TEMP: r_off_t_c  <= i_cfg_data;
                REG_REF_TEMP:    r_ref_t    <= i_cfg_data;
                REG_TEMP_SLOPE:  r_slope_c  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_en    = 1'b0;
        mul_a     = r_dt;
        mul_b     = {2'b0, r_slope_c};
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL_TEMP;
                end
            end
            S_MUL_TEMP: begin
                mul_en  = 1'b1;
                n_state = S_MUL_OFF;
            end
            S_MUL_OFF: begin
                mul_en  = 1'b1;
                mul_b   = {2'b0, r_off_t_c};
                n_state = S_MUL_SENS;
            end
            S_MUL_SENS: begin
                mul_en  = 1'b1;
                mul_b   = {2'b0, r_sens_t_c};
                n_state = S_SENS;
            end
            S_SENS: begin
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                mul_en  = 1'b1;
                mul_a   = {2'b0, r_d1};
                mul_b   = {1'b0, r_sens[16:0]};
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                mul_en  = 1'b1;
                mul_a   = {2'b0, r_d1};
                mul_b   = {r_sens[33], r_sens[33:17]};
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_PRES;
            end
            S_PRES: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_HIST;
            end
            S_HIST: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // arithmetic around the shared multiplier
    always_comb begin
        temp_w    = {r_prod[43], r_prod[43:23]} + TEMP_BASE;
        off_w     = {r_prod[43], r_prod[43:7]} + {6'b0, r_off_c, 16'b0};
        sens_w    = r_prod[43:8] + {5'b0, r_sens_c, 15'b0};
        pres_diff = {r_acc[59], r_acc[59:21]} - {{2{r_off[37]}}, r_off};
        oldest    = (WINDOW_LEN > 1) ? r_hist[0] : r_p;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_d1 <= i_in.raw_pressure;
            r_dt <= $signed({2'b0, i_in.raw_temperature}) - $signed({2'b0, r_ref_t, 8'b0});
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (r_state)
            S_MUL_OFF:  r_temp <= temp_w[TEMP_W-1:0];
            S_MUL_SENS: r_off  <= off_w;
            S_SENS:     r_sens <= sens_w[33:0];
            S_ACC:      r_acc  <= r_acc + {r_prod[42:0], 17'b0};
            S_PRES:     r_p    <= {{7{pres_diff[39]}}, pres_diff[39:15]};
            S_SUM:      r_sum  <= r_hsum + {{(SUM_W-PRES_W){r_p[PRES_W-1]}}, r_p};
            default: ;
        endcase
        if (r_state == S_MUL_HI) begin
            r_acc <= {{16{r_prod[43]}}, r_prod};
        end
    end

    // pressure window with running sum of the stored entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsum <= '0;
            for (int i = 0; i < HIST_D; i++) begin
                r_hist[i] <= '0;
            end
        end else if (r_state == S_HIST) begin
            r_hsum <= r_sum - {{(SUM_W-PRES_W){oldest[PRES_W-1]}}, oldest};
            for (int i = 0; i < HIST_D - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[HIST_D-1] <= r_p;
        end
    end

    bsca_div #(
        .DIVISOR (WINDOW_LEN),
        .IN_W    (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out.temperature  <= r_temp;
            r_out.pressure_avg <= div_quot[PRES_W-1:0];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: bench/tb_top.sv
// testbench: barometric compensation core checked against its own integer predictor
`timescale 1ns / 1ps

module tb_top;
    import bsca_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 140;
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};
    // indexes past the register file
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    class baro_scoreboard;
        logic [CFG_W-1:0] sens_c, off_c, sens_tc, off_tc, tref, tslope;
        int               hist[WINDOW_LEN_DEF-1];
        t_out_req         pending_results[$];
        int               mismatches;

        function new();
            sens_c     = RST_SENS;
            off_c      = RST_OFFSET;
            sens_tc    = RST_SENS_TEMP;
            off_tc     = RST_OFFSET_TEMP;
            tref       = RST_REF_TEMP;
            tslope     = RST_TEMP_SLOPE;
            mismatches = 0;
            foreach (hist[i]) hist[i] = 0;
        endfunction

        function void set_coeff(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_SENS:        sens_c  = data;
                REG_OFFSET:      off_c   = data;
                REG_SENS_TEMP:   sens_tc = data;
                REG_OFFSET_TEMP: off_tc  = data;
                REG_REF_TEMP:    tref    = data;
                REG_TEMP_SLOPE:  tslope  = data;
                default: ;
            endcase
        endfunction

        function t_out_req compensate(t_in_req r);
            longint   d1, d2, dt, temp, off, sens, p, sum;
            t_out_req res;
            d1   = r.raw_pressure;
            d2   = r.raw_temperature;
            dt   = d2 - longint'(tref) * 256;
            temp = 2000 + ((dt * longint'(tslope)) >>> 23);
            off  = longint'(off_c) * 65536 + ((longint'(off_tc) * dt) >>> 7);
            sens = longint'(sens_c) * 32768 + ((longint'(sens_tc) * dt) >>> 8);
            p    = (((d1 * sens) >>> 21) - off) >>> 15;
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            sum = p;
            foreach (hist[i]) sum += hist[i];
            for (int i = 0; i < WINDOW_LEN_DEF - 2; i++) hist[i] = hist[i+1];
            hist[WINDOW_LEN_DEF-2] = int'(p);
            sum = sum / WINDOW_LEN_DEF;
            res.temperature  = temp[TEMP_W-1:0];
            res.pressure_avg = sum[PRES_W-1:0];
            return res;
        endfunction

        function void note_request(t_in_req r);
            pending_results.push_back(compensate(r));
        endfunction

        function void check_result(t_out_req got);
            t_out_req want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: temperature %0d pressure_avg %0d",
                       got.temperature, got.pressure_avg);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.temperature !== want.temperature) begin
                $error("temperature: expected %0d actual %0d",
                       want.temperature, got.temperature);
                mismatches++;
            end
            if (got.pressure_avg !== want.pressure_avg) begin
                $error("pressure_avg: expected %0d actual %0d",
                       want.pressure_avg, got.pressure_avg);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_req              i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_req             o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    baro_scoreboard sb;
    int             cycle_count;
    int             burst_left;
    int             rx_mode;
    int             rx_left;

    baro_sensor_compensation_average_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = (rx_mode == 3) ? $urandom_range(1, 40) : $urandom_range(16, 200);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= $urandom_range(0, 1);
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
    end

    function automatic t_in_req make_req(logic [RAW_W-1:0] p, logic [RAW_W-1:0] t);
        t_in_req r;
        r.raw_pressure    = p;
        r.raw_temperature = t;
        return r;
    endfunction

    function automatic logic [RAW_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return RAW_MAX;
            2:       return RAW_W'(1) << $urandom_range(0, RAW_W - 1);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic t_in_req random_req();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                return make_req(RAW_W'($urandom), RAW_W'($urandom));
            6, 7:
                // readings near a live operating point
                return make_req(RAW_W'($urandom_range(8800000, 9400000)),
                                RAW_W'(int'(sb.tref) * 256 + int'($urandom_range(0, 400000))
                                       - 200000));
            default:
                return make_req(pick_extreme(), pick_extreme());
        endcase
    endfunction

    task automatic send_request(input t_in_req r);
        i_in       <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic issue(input t_in_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_request(r);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_coeff(idx, data);
    endtask

    task automatic program_coeffs(input logic [CFG_W-1:0] sens, off, sens_t, off_t,
                                  tref, slope);
        wait_drained();
        cfg_write(REG_SENS, sens);
        cfg_write(REG_OFFSET, off);
        cfg_write(REG_SENS_TEMP, sens_t);
        cfg_write(REG_OFFSET_TEMP, off_t);
        cfg_write(REG_REF_TEMP, tref);
        cfg_write(REG_TEMP_SLOPE, slope);
        // must not land anywhere
        cfg_write(IDX_SPARE_LO, CFG_W'($urandom));
        cfg_write(IDX_SPARE_HI, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_corners();
        issue(make_req('0, '0));
        issue(make_req(RAW_MAX, RAW_MAX));
        issue(make_req('0, RAW_MAX));
        issue(make_req(RAW_MAX, '0));
    endtask

    task automatic random_phase();
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1) wait_drained();
            issue(random_req());
        end
    endtask

    function automatic logic [CFG_W-1:0] rand_coeff();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_MAX;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    initial begin
        sb          = new();
        cycle_count <= 0;
        burst_left  = 0;
        rx_left     = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start-up window fills from zeros under reset coefficients
        send_corners();
        issue(make_req(RAW_MAX, RAW_W'(RST_REF_TEMP) << 8));
        issue(make_req('0, RAW_W'(RST_REF_TEMP) << 8));
        issue(make_req(24'd9085466, 24'd8569150));
        issue(make_req(24'd1, 24'd1));
        issue(make_req(24'h800000, 24'h800000));
        issue(make_req(24'h555555, 24'haaaaaa));
        issue(make_req(24'haaaaaa, 24'h555555));
        issue(make_req(RAW_MAX, 24'h7fffff));
        issue(make_req(24'd8000000, '0));
        random_phase();

        program_coeffs('0, '0, '0, '0, '0, '0);
        send_corners();
        random_phase();

        program_coeffs(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
        send_corners();
        random_phase();

        program_coeffs(CFG_MAX, '0, '0, CFG_MAX, '0, CFG_MAX);
        send_corners();
        random_phase();

        program_coeffs('0, CFG_MAX, CFG_MAX, '0, CFG_MAX, '0);
        random_phase();

        repeat (2) begin
            program_coeffs(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
                           rand_coeff(), rand_coeff());
            random_phase();
        end

        program_coeffs(RST_SENS, RST_OFFSET, RST_SENS_TEMP, RST_OFFSET_TEMP,
                       RST_REF_TEMP, RST_TEMP_SLOPE);
        random_phase();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
